// ===== sv/mluf_pkg.sv =====
// Shared constants for the MUSCL limited upwind flux block.
// No dependencies; imported by the top level and by its checker.
package mluf_pkg;

    localparam int DATA_W_DEF  = 32;   // default data width, signed Q15.16
    localparam int DATA_W_MAX  = 59;   // widest data the arithmetic carries
    localparam int COS_W       = 18;   // direction cosine, signed Q1.16
    localparam int COS_FRAC    = 16;
    localparam int INV_W       = 32;   // reciprocal cell width, unsigned Q16.16
    localparam int INV_FRAC    = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = INV_W;
    localparam int SCALE_SHIFT = 2 + COS_FRAC + INV_FRAC;
    localparam int LATENCY     = 7;    // accept edge to result strobe, in cycles

    localparam logic [INV_W-1:0] INV_RESET = INV_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV_DX = CFG_IDX_W'(0),
        CFG_INV_DY = CFG_IDX_W'(1)
    } t_cfg_idx;

endpackage

// ===== sv/muscl_limited_upwind_flux_top.sv =====
// MUSCL upwind flux divergence with monotonized-central limiter, 2-D.
// Seven-stage pipeline; uses mluf_pkg for widths, register codes and latency.
//
//   channel   handshake                  payload
//   -------   -------------------------  ------------------------------------
//   input     start / busy               i_y_*, i_center_value, i_x_*, cosines
//   result    o_flux_valid (one cycle)   o_flux_value
//   config    i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One beat enters per clock while busy is low; its result strobes on o_flux_valid
// once it has passed the seven register stages, each holding one slice of the
// work: capture, limiter, face difference plus cosine-by-reciprocal multiply,
// partial products, magnitude sum, signed sum with rounding, and shift with
// saturation. The receiver cannot stall, so nothing holds the line.
// busy is high only while i_rst_n is low; reset clears the valid chain.
module muscl_limited_upwind_flux_top
    import mluf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [DATA_WIDTH-1:0]  i_y_minus_two,
    input  logic signed [DATA_WIDTH-1:0]  i_y_minus_one,
    input  logic signed [DATA_WIDTH-1:0]  i_center_value,
    input  logic signed [DATA_WIDTH-1:0]  i_y_plus_one,
    input  logic signed [DATA_WIDTH-1:0]  i_y_plus_two,
    input  logic signed [DATA_WIDTH-1:0]  i_x_minus_two,
    input  logic signed [DATA_WIDTH-1:0]  i_x_minus_one,
    input  logic signed [DATA_WIDTH-1:0]  i_x_plus_one,
    input  logic signed [DATA_WIDTH-1:0]  i_x_plus_two,
    input  logic signed [COS_W-1:0]       i_dir_x_cosine,
    input  logic signed [COS_W-1:0]       i_dir_y_cosine,
    input  logic                          i_cfg_we,
    input  logic        [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic        [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                          o_flux_valid,
    output logic signed [DATA_WIDTH-1:0]  o_flux_value
);

    // Effective data width: wider ports keep only the low bits.
    localparam int EW   = (DATA_WIDTH > DATA_W_MAX) ? DATA_W_MAX : DATA_WIDTH;
    localparam int SLW  = EW + 3;              // twice a limited slope
    localparam int DW4  = EW + 5;              // four times a face difference
    localparam int CI_W = COS_W + INV_W;       // |cosine| * reciprocal
    localparam int CIH  = CI_W / 2;            // low half of that product
    localparam int CIH2 = CI_W - CIH;          // high half
    localparam int DC   = 32;                  // chunk of |diff4| per multiplier
    localparam int NDC  = (DW4 + DC - 1) / DC;
    localparam int PDW  = NDC * DC;
    localparam int PPW  = DC + CIH2;           // one partial product
    localparam int ACCW = PDW + CI_W;
    localparam int MW   = DW4 + CI_W;          // exact axis magnitude
    localparam int SW   = MW + 2;              // signed sum of both axes
    localparam int QW   = SW - SCALE_SHIFT;

    // ---------------------------------------------------------------- helpers
    function automatic logic signed [SLW-1:0] f_minmod(
        input logic signed [SLW-1:0] a,
        input logic signed [SLW-1:0] b
    );
        logic signed [SLW-1:0] res;
        res = '0;
        if (a > 0 && b > 0) begin
            res = (a < b) ? a : b;
        end else if (a < 0 && b < 0) begin
            res = (a > b) ? a : b;
        end
        return res;
    endfunction

    // Twice the limited slope: minmod(4(r-c), minmod(r-l, 4(c-l))).
    function automatic logic signed [SLW-1:0] f_slope2(
        input logic signed [EW-1:0] l,
        input logic signed [EW-1:0] c,
        input logic signed [EW-1:0] r
    );
        logic signed [SLW-1:0] lx, cx, rx;
        lx = {{3{l[EW-1]}}, l};
        cx = {{3{c[EW-1]}}, c};
        rx = {{3{r[EW-1]}}, r};
        return f_minmod((rx - cx) <<< 2, f_minmod(rx - lx, (cx - lx) <<< 2));
    endfunction

    // ---------------------------------------------------------- configuration
    logic [INV_W-1:0] r_inv_dx, r_inv_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_dx <= INV_RESET;
            r_inv_dy <= INV_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_INV_DX) r_inv_dx <= i_cfg_data[INV_W-1:0];
            if (i_cfg_idx == CFG_INV_DY) r_inv_dy <= i_cfg_data[INV_W-1:0];
        end
    end

    // ------------------------------------------------------------ valid chain
    logic               w_accept;
    logic [LATENCY-1:0] r_vld;

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], w_accept};
        end
    end

    // Axis index 0 is x, 1 is y throughout.

    // ---------------------------------------------- stage 1: capture the beat
    logic signed [EW-1:0]    r_s1_m2 [2];
    logic signed [EW-1:0]    r_s1_m1 [2];
    logic signed [EW-1:0]    r_s1_p1 [2];
    logic signed [EW-1:0]    r_s1_p2 [2];
    logic signed [EW-1:0]    r_s1_c;
    logic signed [COS_W-1:0] r_s1_cos [2];

    always_ff @(posedge i_clk) begin
        r_s1_m2[0]  <= i_x_minus_two[EW-1:0];
        r_s1_m1[0]  <= i_x_minus_one[EW-1:0];
        r_s1_p1[0]  <= i_x_plus_one[EW-1:0];
        r_s1_p2[0]  <= i_x_plus_two[EW-1:0];
        r_s1_m2[1]  <= i_y_minus_two[EW-1:0];
        r_s1_m1[1]  <= i_y_minus_one[EW-1:0];
        r_s1_p1[1]  <= i_y_plus_one[EW-1:0];
        r_s1_p2[1]  <= i_y_plus_two[EW-1:0];
        r_s1_c      <= i_center_value[EW-1:0];
        r_s1_cos[0] <= i_dir_x_cosine;
        r_s1_cos[1] <= i_dir_y_cosine;
    end

    // ------------------------------------------------ stage 2: limited slopes
    // diff4 = base + s_center - s_other for either upwind side.
    logic signed [SLW-1:0]   n_s2_base [2], r_s2_base [2];
    logic signed [SLW-1:0]   n_s2_sc   [2], r_s2_sc   [2];
    logic signed [SLW-1:0]   n_s2_so   [2], r_s2_so   [2];
    logic signed [COS_W-1:0] r_s2_cos  [2];

    always_comb begin
        logic                  from_minus;
        logic signed [SLW-1:0] cx, m1x, p1x;
        for (int a = 0; a < 2; a++) begin
            from_minus = ~r_s1_cos[a][COS_W-1] && (r_s1_cos[a] != '0);
            cx  = {{3{r_s1_c[EW-1]}}, r_s1_c};
            m1x = {{3{r_s1_m1[a][EW-1]}}, r_s1_m1[a]};
            p1x = {{3{r_s1_p1[a][EW-1]}}, r_s1_p1[a]};
            n_s2_sc[a] = f_slope2(r_s1_m1[a], r_s1_c, r_s1_p1[a]);
            if (from_minus) begin
                n_s2_base[a] = (cx - m1x) <<< 2;
                n_s2_so[a]   = f_slope2(r_s1_m2[a], r_s1_m1[a], r_s1_c);
            end else begin
                n_s2_base[a] = (p1x - cx) <<< 2;
                n_s2_so[a]   = f_slope2(r_s1_c, r_s1_p1[a], r_s1_p2[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_base <= n_s2_base;
        r_s2_sc   <= n_s2_sc;
        r_s2_so   <= n_s2_so;
        r_s2_cos  <= r_s1_cos;
    end

    // ------------------- stage 3: face difference, magnitudes, |cos| * inv
    logic [DW4-1:0]  n_s3_dm [2], r_s3_dm [2];
    logic [CI_W-1:0] n_s3_ci [2], r_s3_ci [2];
    logic            n_s3_neg [2], r_s3_neg [2];

    always_comb begin
        logic signed [DW4-1:0] d4;
        logic        [COS_W-1:0] cm;
        logic        [INV_W-1:0] inv;
        for (int a = 0; a < 2; a++) begin
            d4 = {{2{r_s2_base[a][SLW-1]}}, r_s2_base[a]}
               + {{2{r_s2_sc[a][SLW-1]}},   r_s2_sc[a]}
               - {{2{r_s2_so[a][SLW-1]}},   r_s2_so[a]};
            n_s3_dm[a]  = d4[DW4-1] ? DW4'(-d4) : DW4'(d4);
            cm          = r_s2_cos[a][COS_W-1] ? COS_W'(-r_s2_cos[a])
                                               : COS_W'(r_s2_cos[a]);
            inv         = (a == 0) ? r_inv_dx : r_inv_dy;
            n_s3_ci[a]  = CI_W'(cm) * CI_W'(inv);
            n_s3_neg[a] = d4[DW4-1] ^ r_s2_cos[a][COS_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_dm  <= n_s3_dm;
        r_s3_ci  <= n_s3_ci;
        r_s3_neg <= n_s3_neg;
    end

    // ------------------------------------------ stage 4: partial products
    // Cut |diff4| into 32-bit chunks and |cos|*inv into two halves.
    logic [PPW-1:0] n_s4_pp [2][NDC][2], r_s4_pp [2][NDC][2];
    logic           r_s4_neg [2];

    always_comb begin
        logic [PDW-1:0]  dmp;
        logic [CIH2-1:0] ch [2];
        for (int a = 0; a < 2; a++) begin
            dmp   = PDW'(r_s3_dm[a]);
            ch[0] = CIH2'(r_s3_ci[a][CIH-1:0]);
            ch[1] = r_s3_ci[a][CI_W-1:CIH];
            for (int k = 0; k < NDC; k++) begin
                for (int h = 0; h < 2; h++) begin
                    n_s4_pp[a][k][h] = PPW'(dmp[k*DC +: DC]) * PPW'(ch[h]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_pp  <= n_s4_pp;
        r_s4_neg <= r_s3_neg;
    end

    // --------------------------------------- stage 5: axis magnitude sums
    logic [MW-1:0] n_s5_mag [2], r_s5_mag [2];
    logic          r_s5_neg [2];

    always_comb begin
        logic [ACCW-1:0] acc;
        for (int a = 0; a < 2; a++) begin
            acc = '0;
            for (int k = 0; k < NDC; k++) begin
                for (int h = 0; h < 2; h++) begin
                    acc = acc + (ACCW'(r_s4_pp[a][k][h]) << (k*DC + h*CIH));
                end
            end
            n_s5_mag[a] = acc[MW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_mag <= n_s5_mag;
        r_s5_neg <= r_s4_neg;
    end

    // ------------------- stage 6: signed sum of both axes plus half an LSB
    // Negate by invert and carry-in so both signs fold into one add.
    logic [SW-1:0] n_s6_sum, r_s6_sum;

    always_comb begin
        logic [SW-1:0] tx, ty, half;
        tx   = SW'(r_s5_mag[0]) ^ {SW{r_s5_neg[0]}};
        ty   = SW'(r_s5_mag[1]) ^ {SW{r_s5_neg[1]}};
        half = SW'(1) << (SCALE_SHIFT - 1);
        n_s6_sum = tx + ty + half + SW'(r_s5_neg[0]) + SW'(r_s5_neg[1]);
    end

    always_ff @(posedge i_clk) begin
        r_s6_sum <= n_s6_sum;
    end

    // ------------------------------------- stage 7: scale down and saturate
    logic [EW-1:0] n_flux, r_flux;

    always_comb begin
        logic [QW-1:0] q;
        logic          in_range;
        q        = r_s6_sum[SW-1:SCALE_SHIFT];
        in_range = (&q[QW-1:EW-1]) | ~(|q[QW-1:EW-1]);
        if (in_range) begin
            n_flux = q[EW-1:0];
        end else if (q[QW-1]) begin
            n_flux = {1'b1, {(EW-1){1'b0}}};
        end else begin
            n_flux = {1'b0, {(EW-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_flux <= n_flux;
    end

    assign o_flux_valid = r_vld[LATENCY-1];
    assign o_flux_value = DATA_WIDTH'(r_flux);

endmodule

// ===== sv/mluf_checker.sv =====
// Port-level checker for muscl_limited_upwind_flux_top, with its bind.
// Depends on mluf_pkg for the default data width, the cosine width and latency.
module mluf_checker
    import mluf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_W_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic signed [DATA_WIDTH-1:0]  i_y_minus_two,
    input logic signed [DATA_WIDTH-1:0]  i_y_minus_one,
    input logic signed [DATA_WIDTH-1:0]  i_center_value,
    input logic signed [DATA_WIDTH-1:0]  i_y_plus_one,
    input logic signed [DATA_WIDTH-1:0]  i_y_plus_two,
    input logic signed [DATA_WIDTH-1:0]  i_x_minus_two,
    input logic signed [DATA_WIDTH-1:0]  i_x_minus_one,
    input logic signed [DATA_WIDTH-1:0]  i_x_plus_one,
    input logic signed [DATA_WIDTH-1:0]  i_x_plus_two,
    input logic signed [COS_W-1:0]       i_dir_x_cosine,
    input logic signed [COS_W-1:0]       i_dir_y_cosine,
    input logic                          o_flux_valid,
    input logic signed [DATA_WIDTH-1:0]  o_flux_value
);

    logic w_acc, w_flat, w_still;

    assign w_acc   = start && !busy;
    assign w_still = (i_dir_x_cosine == '0) && (i_dir_y_cosine == '0);
    assign w_flat  = (i_y_minus_two == i_center_value) && (i_y_minus_one == i_center_value)
                  && (i_y_plus_one  == i_center_value) && (i_y_plus_two  == i_center_value)
                  && (i_x_minus_two == i_center_value) && (i_x_minus_one == i_center_value)
                  && (i_x_plus_one  == i_center_value) && (i_x_plus_two  == i_center_value);

    // Every accepted beat is followed by a result strobe.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> ##LATENCY o_flux_valid)
        else $error("accepted beat produced no result");

    // No result strobe without a matching beat accepted earlier.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_flux_valid |-> $past(w_acc, LATENCY))
        else $error("result strobe without an accepted beat");

    // Both cosines zero: both axis terms vanish, flux is zero.
    a_still_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_still) |-> ##LATENCY (o_flux_value == '0))
        else $error("zero direction gave nonzero flux");

    // Flat stencil: every face difference is zero, flux is zero.
    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_flat) |-> ##LATENCY (o_flux_value == '0))
        else $error("flat stencil gave nonzero flux");

endmodule

bind muscl_limited_upwind_flux_top mluf_checker #(
    .DATA_WIDTH(DATA_WIDTH)
) u_mluf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_y_minus_two  (i_y_minus_two),
    .i_y_minus_one  (i_y_minus_one),
    .i_center_value (i_center_value),
    .i_y_plus_one   (i_y_plus_one),
    .i_y_plus_two   (i_y_plus_two),
    .i_x_minus_two  (i_x_minus_two),
    .i_x_minus_one  (i_x_minus_one),
    .i_x_plus_one   (i_x_plus_one),
    .i_x_plus_two   (i_x_plus_two),
    .i_dir_x_cosine (i_dir_x_cosine),
    .i_dir_y_cosine (i_dir_y_cosine),
    .o_flux_valid   (o_flux_valid),
    .o_flux_value   (o_flux_value)
);
